FILE: design/wpas_pkg.sv
// Shared types, register codes and fixed-point constants of the windowed PID angle servo.
package wpas_pkg;

   // Default encoder resolution; a full turn equals 2**ENCODER_BITS counts.
   localparam int ENCODER_BITS_DEFAULT = 14;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int GAIN_W     = 24;
   localparam int DEG_W      = 9;
   localparam int CSR_DATA_W = GAIN_W;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_KP           = 3'd0;
   localparam csr_addr_type CSR_KI_DT        = 3'd1;
   localparam csr_addr_type CSR_KD_OVER_DT   = 3'd2;
   localparam csr_addr_type CSR_TARGET_ANGLE = 3'd3;
   localparam csr_addr_type CSR_WINDOW_LOW   = 3'd4;
   localparam csr_addr_type CSR_WINDOW_HIGH  = 3'd5;

   localparam logic [GAIN_W-1:0] KP_RESET           = 24'd45875;
   localparam logic [GAIN_W-1:0] KI_DT_RESET        = 24'd66;
   localparam logic [GAIN_W-1:0] KD_OVER_DT_RESET   = 24'd327680;
   localparam logic [DEG_W-1:0]  TARGET_ANGLE_RESET = 9'd90;
   localparam logic [DEG_W-1:0]  WINDOW_LOW_RESET   = 9'd35;
   localparam logic [DEG_W-1:0]  WINDOW_HIGH_RESET  = 9'd85;

   // Angles in unsigned Q.8 degrees.
   localparam int ANGLE_W = 17;
   localparam logic [ANGLE_W-1:0] FULL_TURN_Q8 = 17'd92160;

   // Error before wrapping spans target*256 - angle and is held in 19 signed bits.
   localparam int ERR_RAW_W = 19;
   localparam logic signed [ERR_RAW_W-1:0] HALF_TURN_Q8_S = 19'sd46080;
   localparam logic signed [ERR_RAW_W-1:0] FULL_TURN_Q8_S = 19'sd92160;

   // Wrapped error lies within +-180 degrees, the difference within +-360.
   localparam int ERR_W  = 17;
   localparam int DIFF_W = 18;
   localparam int SUM_W  = 32;

   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam sum_type SUM_MAX = 32'sh7FFF_FFFF;
   localparam sum_type SUM_MIN = 32'sh8000_0000;

   // Products of a zero-extended Q8.16 gain with the Q.8 terms, in Q.24 degrees.
   localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
   localparam int I_PROD_W = GAIN_W + 1 + SUM_W;
   localparam int D_PROD_W = GAIN_W + 1 + DIFF_W;
   localparam int PID_W    = I_PROD_W + 1;
   localparam int FRAC_W   = 24;

   typedef logic signed [PID_W-1:0] pid_type;

   localparam pid_type LIMIT_Q24 = 58'sd1509949440;

   // Servo command.
   localparam int CMD_W = 8;
   localparam logic [CMD_W-1:0] NEUTRAL_CMD = 8'd90;

endpackage

FILE: design/windowed_pid_angle_servo.sv
// Top level of the windowed PID angle servo: encoder sample in, servo command out.
//
// The block turns raw rotary encoder samples into servo position commands.
// Samples arrive on the req_ stream, one per transfer, in the low ENCODER_BITS
// of req_tdata; higher bits are ignored. Each sample gives exactly one result
// on the rsp_ stream: the command in whole degrees (0 to 180, 90 neutral) on
// rsp_tdata, and two flags on rsp_tuser telling whether the angle was inside
// the control window and whether the PID sum was clamped at plus or minus 90.
// Gains, setpoint and window bounds are written through the csr_ port, which
// is always ready; write it only while no sample is in flight.
//
// The pipeline has four register stages: input, error and integrator, the
// three gain products, and the result. One sample can be taken every cycle
// while the receiver does not stall. The integrator and previous-error
// state are updated as an in-window sample leaves the input stage, so
// back-to-back samples see each other's effect in order. When the receiver
// stalls, each stage holds its contents and the back pressure ripples
// upstream; req_tready falls only once all four stages are full. Reset
// empties the pipeline, clears the integrator and previous error, and
// restores the register reset values. It takes effect synchronously.
module windowed_pid_angle_servo #(
   parameter int ENCODER_BITS = wpas_pkg::ENCODER_BITS_DEFAULT,
   localparam int REQ_W = ((ENCODER_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // Sample stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_W-1:0]                 req_tdata,  // encoder_angle
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wpas_pkg::CMD_W-1:0]       rsp_tdata,  // servo_command
   output logic [1:0]                       rsp_tuser,  // in_window, output_clamped
   // Register writes.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  wpas_pkg::csr_addr_type           csr_addr,
   input  logic [wpas_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SCALED_W = ENCODER_BITS + wpas_pkg::ANGLE_W;

   // Configuration registers.
   logic [wpas_pkg::GAIN_W-1:0] kp_ff, ki_dt_ff, kd_over_dt_ff;
   logic [wpas_pkg::DEG_W-1:0]  target_ff, window_low_ff, window_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= wpas_pkg::KP_RESET;
         ki_dt_ff       <= wpas_pkg::KI_DT_RESET;
         kd_over_dt_ff  <= wpas_pkg::KD_OVER_DT_RESET;
         target_ff      <= wpas_pkg::TARGET_ANGLE_RESET;
         window_low_ff  <= wpas_pkg::WINDOW_LOW_RESET;
         window_high_ff <= wpas_pkg::WINDOW_HIGH_RESET;
      end else if (csr_valid) begin
         unique case (csr_addr)
            wpas_pkg::CSR_KP:           kp_ff          <= csr_wdata;
            wpas_pkg::CSR_KI_DT:        ki_dt_ff       <= csr_wdata;
            wpas_pkg::CSR_KD_OVER_DT:   kd_over_dt_ff  <= csr_wdata;
            wpas_pkg::CSR_TARGET_ANGLE: target_ff      <= csr_wdata[wpas_pkg::DEG_W-1:0];
            wpas_pkg::CSR_WINDOW_LOW:   window_low_ff  <= csr_wdata[wpas_pkg::DEG_W-1:0];
            wpas_pkg::CSR_WINDOW_HIGH:  window_high_ff <= csr_wdata[wpas_pkg::DEG_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage occupancy and flow control. Each stage may load when it is empty
   // or when its contents move on in the same cycle.
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic a_ready, b_ready, c_ready, out_ready;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign c_ready    = !c_valid_ff || out_ready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready)   a_valid_ff   <= req_tvalid;
         if (b_ready)   b_valid_ff   <= a_valid_ff;
         if (c_ready)   c_valid_ff   <= b_valid_ff;
         if (out_ready) rsp_valid_ff <= c_valid_ff;
      end
   end

   // Stage A: the registered raw sample.
   logic [ENCODER_BITS-1:0] raw_a_ff;

   always_ff @(posedge clock) begin
      if (a_ready && req_tvalid) begin
         raw_a_ff <= req_tdata[ENCODER_BITS-1:0];
      end
   end

   // Angle in Q.8 degrees: raw * 360 * 256 / 2**ENCODER_BITS, truncated.
   logic [SCALED_W-1:0]              scaled;
   logic [wpas_pkg::ANGLE_W-1:0]     angle, win_lo, win_hi;
   logic                             in_win_a;

   assign scaled   = SCALED_W'(raw_a_ff) * SCALED_W'(wpas_pkg::FULL_TURN_Q8);
   assign angle    = scaled[SCALED_W-1:ENCODER_BITS];
   assign win_lo   = {window_low_ff, 8'h00};
   assign win_hi   = {window_high_ff, 8'h00};
   assign in_win_a = (angle >= win_lo) && (angle <= win_hi);

   // Error, wrapped once into +-180 degrees.
   logic signed [wpas_pkg::ERR_RAW_W-1:0] err_raw, err_wrap;
   wpas_pkg::err_type                     err_a;

   assign err_raw = $signed({2'b00, target_ff, 8'h00}) - $signed({2'b00, angle});

   always_comb begin
      if (err_raw > wpas_pkg::HALF_TURN_Q8_S) begin
         err_wrap = err_raw - wpas_pkg::FULL_TURN_Q8_S;
      end else if (err_raw < -wpas_pkg::HALF_TURN_Q8_S) begin
         err_wrap = err_raw + wpas_pkg::FULL_TURN_Q8_S;
      end else begin
         err_wrap = err_raw;
      end
   end

   assign err_a = wpas_pkg::err_type'(err_wrap);

   // Integrator with saturation at the signed 32-bit limits, and the
   // derivative difference against the last in-window error.
   wpas_pkg::sum_type            error_sum_ff, error_sum_in;
   wpas_pkg::err_type            prev_err_ff;
   logic signed [wpas_pkg::SUM_W:0] sum_wide;
   wpas_pkg::diff_type           diff_a;

   assign sum_wide = $signed({error_sum_ff[wpas_pkg::SUM_W-1], error_sum_ff})
                   + (wpas_pkg::SUM_W + 1)'(err_a);

   always_comb begin
      if (sum_wide[wpas_pkg::SUM_W] != sum_wide[wpas_pkg::SUM_W-1]) begin
         error_sum_in = sum_wide[wpas_pkg::SUM_W] ? wpas_pkg::SUM_MIN : wpas_pkg::SUM_MAX;
      end else begin
         error_sum_in = sum_wide[wpas_pkg::SUM_W-1:0];
      end
   end

   assign diff_a = wpas_pkg::diff_type'(err_a) - wpas_pkg::diff_type'(prev_err_ff);

   // The state advances only for an in-window sample leaving stage A, so an
   // outside sample leaves it untouched.
   logic state_update;

   assign state_update = a_valid_ff && b_ready && in_win_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else if (state_update) begin
         error_sum_ff <= error_sum_in;
         prev_err_ff  <= err_a;
      end
   end

   // Stage B: error terms.
   wpas_pkg::err_type  err_b_ff;
   wpas_pkg::sum_type  sum_b_ff;
   wpas_pkg::diff_type diff_b_ff;
   logic               win_b_ff;

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         err_b_ff  <= err_a;
         sum_b_ff  <= error_sum_in;
         diff_b_ff <= diff_a;
         win_b_ff  <= in_win_a;
      end
   end

   // The three gain products, each registered before they are summed.
   logic signed [wpas_pkg::P_PROD_W-1:0] p_prod, p_c_ff;
   logic signed [wpas_pkg::I_PROD_W-1:0] i_prod, i_c_ff;
   logic signed [wpas_pkg::D_PROD_W-1:0] d_prod, d_c_ff;
   logic                                 win_c_ff;

   assign p_prod = $signed({1'b0, kp_ff}) * err_b_ff;
   assign i_prod = $signed({1'b0, ki_dt_ff}) * sum_b_ff;
   assign d_prod = $signed({1'b0, kd_over_dt_ff}) * diff_b_ff;

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) begin
         p_c_ff   <= p_prod;
         i_c_ff   <= i_prod;
         d_c_ff   <= d_prod;
         win_c_ff <= win_b_ff;
      end
   end

   // Sum, clamp to +-90 degrees and convert to a command: (90 - pid) in whole
   // degrees. The difference is never negative, so truncation is a shift.
   wpas_pkg::pid_type           pid_sum, pid_clamped, cmd_q24;
   logic                        clamped;
   logic [wpas_pkg::CMD_W-1:0]  cmd_in;
   logic [1:0]                  flags_in;

   assign pid_sum = wpas_pkg::pid_type'(p_c_ff) + wpas_pkg::pid_type'(i_c_ff)
                  + wpas_pkg::pid_type'(d_c_ff);

   always_comb begin
      if (pid_sum > wpas_pkg::LIMIT_Q24) begin
         pid_clamped = wpas_pkg::LIMIT_Q24;
         clamped     = 1'b1;
      end else if (pid_sum < -wpas_pkg::LIMIT_Q24) begin
         pid_clamped = -wpas_pkg::LIMIT_Q24;
         clamped     = 1'b1;
      end else begin
         pid_clamped = pid_sum;
         clamped     = 1'b0;
      end
   end

   assign cmd_q24 = wpas_pkg::LIMIT_Q24 - pid_clamped;

   always_comb begin
      if (win_c_ff) begin
         cmd_in   = cmd_q24[wpas_pkg::FRAC_W +: wpas_pkg::CMD_W];
         flags_in = {clamped, 1'b1};
      end else begin
         cmd_in   = wpas_pkg::NEUTRAL_CMD;
         flags_in = 2'b00;
      end
   end

   // Result register.
   logic [wpas_pkg::CMD_W-1:0] cmd_ff;
   logic [1:0]                 flags_ff;

   always_ff @(posedge clock) begin
      if (out_ready && c_valid_ff) begin
         cmd_ff   <= cmd_in;
         flags_ff <= flags_in;
      end
   end

   assign rsp_tdata = cmd_ff;
   assign rsp_tuser = flags_ff;

endmodule

FILE: design/wpas_checker.sv
// Port-level checks on the result stream of the windowed PID angle servo, and their binding.
module wpas_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [wpas_pkg::CMD_W-1:0] rsp_tdata,
   input logic [1:0]                 rsp_tuser
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Outside the window the command is neutral and no clamp is reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == wpas_pkg::NEUTRAL_CMD && !rsp_tuser[1])
      else $error("outside-window result is not neutral");

   // The command never leaves the servo range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 8'd180)
      else $error("servo command beyond 180 degrees");

endmodule

bind windowed_pid_angle_servo wpas_checker u_wpas_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
